>>> hw/rtl/ucts_pkg.sv
// shared types and codes for the endpoint-zero control transfer sequencer
// depends on nothing; used by every module of the block
package ucts_pkg;

	// event codes carried in the action field
	localparam logic [2:0] ACT_SETUP     = 3'd0;
	localparam logic [2:0] ACT_IN_DONE   = 3'd1;
	localparam logic [2:0] ACT_OUT_DONE  = 3'd2;
	localparam logic [2:0] ACT_STALL_CLR = 3'd3;
	localparam logic [2:0] ACT_BUS_RESET = 3'd4;

	// endpoint commands
	localparam logic [2:0] CMD_NONE       = 3'd0;
	localparam logic [2:0] CMD_SEND_CHUNK = 3'd1;
	localparam logic [2:0] CMD_SEND_ZLP   = 3'd2;
	localparam logic [2:0] CMD_ARM_STATUS = 3'd3;
	localparam logic [2:0] CMD_ARM_OUT    = 3'd4;
	localparam logic [2:0] CMD_ARM_SETUP  = 3'd5;
	localparam logic [2:0] CMD_DELIVER    = 3'd6;
	localparam logic [2:0] CMD_STALL      = 3'd7;

	// control stages
	localparam logic [1:0] STG_SETUP     = 2'd0;
	localparam logic [1:0] STG_DATA_IN   = 2'd1;
	localparam logic [1:0] STG_DATA_OUT  = 2'd2;
	localparam logic [1:0] STG_STATUS_IN = 2'd3;

	// device states
	localparam logic [1:0] DS_ATTACHED     = 2'd0;
	localparam logic [1:0] DS_ADDR_PENDING = 2'd1;
	localparam logic [1:0] DS_ADDRESSED    = 2'd2;

	// reciprocal scaling for the packet-multiple test
	localparam int RECIP_SHIFT = 24;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [2:0]  action;
		logic        request_dir_in;
		logic        handler_accepted;
		logic [15:0] transfer_length;
		logic        is_set_address;
		logic [6:0]  new_address;
		logic [6:0]  out_byte_count;
	} evt_item_t;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] chunk_length;
		logic [6:0] device_address;
		logic [1:0] stage_now;
	} res_item_t;

	// classified event handed from front to back
	typedef struct packed {
		evt_item_t item;
		logic      zlp_need;
	} cls_evt_t;

endpackage

>>> hw/rtl/ucts_front.sv
// front end: accepts events and classifies the data stage length
// depends on ucts_pkg; feeds ucts_queue
module ucts_front #(
	parameter int MAX_PACKET = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_ready,
	input  ucts_pkg::evt_item_t evt,
	output logic                push_valid,
	input  logic                push_ready,
	output ucts_pkg::cls_evt_t  push_data
);

	localparam int SH      = ucts_pkg::RECIP_SHIFT;
	localparam int RECIP   = ((1 << SH) + MAX_PACKET - 1) / MAX_PACKET;
	localparam int PROD_W  = SH + 16;

	logic                valid_s1;
	ucts_pkg::evt_item_t item_s1;
	logic [15:0]         quot_s1;
	logic                valid_s2;
	ucts_pkg::cls_evt_t  evt_s2;

	logic                adv_s1;
	logic                adv_s2;
	logic [PROD_W-1:0]   prod;
	logic [15:0]         qmul;
	logic                zlp_need;

	// stall chain
	assign adv_s2    = !valid_s2 || push_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign evt_ready = adv_s1;

	// quotient by constant through reciprocal multiply
	assign prod = PROD_W'(evt.transfer_length) * PROD_W'(RECIP);

	// length is a multiple of the packet size and above one packet
	assign qmul     = 16'(quot_s1 * 16'(MAX_PACKET));
	assign zlp_need = (item_s1.transfer_length > 16'(MAX_PACKET)) &&
		(item_s1.transfer_length == qmul);

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && evt_valid) begin
			item_s1 <= evt;
			quot_s1 <= prod[SH+15:SH];
		end
	end

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			evt_s2.item     <= item_s1;
			evt_s2.zlp_need <= zlp_need;
		end
	end

	assign push_valid = valid_s2;
	assign push_data  = evt_s2;

endmodule

>>> hw/rtl/ucts_queue.sv
// short fifo of classified events between front and back
// depends on ucts_pkg
module ucts_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  ucts_pkg::cls_evt_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output ucts_pkg::cls_evt_t pop_data
);

	ucts_pkg::cls_evt_t              mem_q [ucts_pkg::QUEUE_DEPTH];
	logic [ucts_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ucts_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ucts_pkg::QCNT_W-1:0]     count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != ucts_pkg::QCNT_W'(ucts_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hw/rtl/ucts_back.sv
// back end: control stage, address tracking and command output register
// depends on ucts_pkg; drains ucts_queue
module ucts_back #(
	parameter int MAX_PACKET = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  ucts_pkg::cls_evt_t  pop_data,
	output logic                res_valid,
	input  logic                res_ready,
	output ucts_pkg::res_item_t res
);

	localparam logic [15:0] MP16 = 16'(MAX_PACKET);

	logic [1:0]          stage_q;
	logic [15:0]         remaining_q;
	logic                zlp_q;
	logic [1:0]          dstate_q;
	logic [6:0]          paddr_q;
	logic [6:0]          caddr_q;
	logic                res_valid_q;
	ucts_pkg::res_item_t res_q;

	logic [1:0]          n_stage;
	logic [15:0]         n_remaining;
	logic                n_zlp;
	logic [1:0]          n_dstate;
	logic [6:0]          n_paddr;
	logic [6:0]          n_caddr;
	logic [2:0]          n_cmd;
	logic [6:0]          n_clen;
	logic [15:0]         chunk_src;
	logic [15:0]         chunk;
	logic [15:0]         ocount;
	logic [15:0]         out_left;
	logic                take;

	assign take      = pop_valid && (!res_valid_q || res_ready);
	assign pop_ready = !res_valid_q || res_ready;

	// next chunk size, taken from the new length on setup
	assign chunk_src = (pop_data.item.action == ucts_pkg::ACT_SETUP) ?
		pop_data.item.transfer_length : remaining_q;
	assign chunk     = (chunk_src < MP16) ? chunk_src : MP16;

	// out transaction with saturation at zero
	assign ocount   = 16'(pop_data.item.out_byte_count);
	assign out_left = (ocount > remaining_q) ? '0 : remaining_q - ocount;

	// event decode and stage update
	always_comb begin
		n_stage     = stage_q;
		n_remaining = remaining_q;
		n_zlp       = zlp_q;
		n_dstate    = dstate_q;
		n_paddr     = paddr_q;
		n_caddr     = caddr_q;
		n_cmd       = ucts_pkg::CMD_NONE;
		n_clen      = '0;
		case (pop_data.item.action)
			ucts_pkg::ACT_SETUP: begin
				n_stage = ucts_pkg::STG_SETUP;
				if (!pop_data.item.handler_accepted) begin
					n_cmd = ucts_pkg::CMD_STALL;
				end else begin
					if (pop_data.item.is_set_address) begin
						n_dstate = ucts_pkg::DS_ADDR_PENDING;
						n_paddr  = pop_data.item.new_address;
					end
					n_zlp = pop_data.zlp_need;
					if (pop_data.item.request_dir_in) begin
						n_remaining = pop_data.item.transfer_length - chunk;
						n_clen      = chunk[6:0];
						n_stage     = ucts_pkg::STG_DATA_IN;
						n_cmd       = ucts_pkg::CMD_SEND_CHUNK;
					end else begin
						n_remaining = pop_data.item.transfer_length;
						n_stage     = ucts_pkg::STG_DATA_OUT;
						n_cmd       = ucts_pkg::CMD_ARM_OUT;
					end
				end
			end
			ucts_pkg::ACT_IN_DONE: begin
				if (dstate_q == ucts_pkg::DS_ADDR_PENDING && caddr_q == '0) begin
					n_dstate = ucts_pkg::DS_ADDRESSED;
					n_caddr  = paddr_q;
				end
				if (stage_q == ucts_pkg::STG_DATA_IN) begin
					if (remaining_q == '0) begin
						if (zlp_q) begin
							n_zlp = 1'b0;
							n_cmd = ucts_pkg::CMD_SEND_ZLP;
						end else begin
							n_stage = ucts_pkg::STG_STATUS_IN;
							n_cmd   = ucts_pkg::CMD_ARM_STATUS;
						end
					end else begin
						n_remaining = remaining_q - chunk;
						n_clen      = chunk[6:0];
						n_cmd       = ucts_pkg::CMD_SEND_CHUNK;
					end
				end else if (stage_q == ucts_pkg::STG_STATUS_IN) begin
					n_stage = ucts_pkg::STG_SETUP;
					n_zlp   = 1'b0;
					n_cmd   = ucts_pkg::CMD_ARM_SETUP;
				end
			end
			ucts_pkg::ACT_OUT_DONE: begin
				if (stage_q == ucts_pkg::STG_DATA_OUT) begin
					n_remaining = out_left;
					if (out_left == '0) begin
						if (zlp_q) begin
							n_zlp = 1'b0;
							n_cmd = ucts_pkg::CMD_ARM_OUT;
						end else begin
							n_stage = ucts_pkg::STG_SETUP;
							n_cmd   = ucts_pkg::CMD_DELIVER;
						end
					end else begin
						n_cmd = ucts_pkg::CMD_ARM_OUT;
					end
				end else begin
					n_stage = ucts_pkg::STG_SETUP;
					n_zlp   = 1'b0;
					n_cmd   = ucts_pkg::CMD_ARM_SETUP;
				end
			end
			ucts_pkg::ACT_STALL_CLR: begin
				n_stage = ucts_pkg::STG_SETUP;
				n_zlp   = 1'b0;
				n_cmd   = ucts_pkg::CMD_ARM_SETUP;
			end
			ucts_pkg::ACT_BUS_RESET: begin
				// bus reset is ignored while an address waits to be committed
				if (dstate_q != ucts_pkg::DS_ADDR_PENDING) begin
					n_caddr  = '0;
					n_dstate = ucts_pkg::DS_ATTACHED;
					n_stage  = ucts_pkg::STG_SETUP;
					n_zlp    = 1'b0;
					n_cmd    = ucts_pkg::CMD_ARM_SETUP;
				end
			end
			default: begin
				n_cmd = ucts_pkg::CMD_NONE;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ucts_pkg::STG_SETUP;
			remaining_q <= '0;
			zlp_q       <= 1'b0;
			dstate_q    <= ucts_pkg::DS_ATTACHED;
			paddr_q     <= '0;
			caddr_q     <= '0;
		end else if (take) begin
			stage_q     <= n_stage;
			remaining_q <= n_remaining;
			zlp_q       <= n_zlp;
			dstate_q    <= n_dstate;
			paddr_q     <= n_paddr;
			caddr_q     <= n_caddr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop_ready) begin
			res_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.command        <= n_cmd;
			res_q.chunk_length   <= n_clen;
			res_q.device_address <= n_caddr;
			res_q.stage_now      <= n_stage;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hw/rtl/usb_control_transfer_sequencer.sv
// endpoint-zero control transfer sequencer, top level
// depends on ucts_pkg, ucts_front, ucts_queue, ucts_back
//
// usage
//   evt channel (evt_valid / evt_ready / evt): one transaction per bus event on
//   endpoint zero: setup received, IN done, OUT done, stall cleared, bus reset.
//   res channel (res_valid / res_ready / res): exactly one transaction per event,
//   in order, carrying the endpoint command, the IN chunk length, the address in
//   use and the control stage after the event.
//   path: an accepted event passes two front pipeline registers, one queue slot
//   and one output register before its result is presented.
//   throughput: one event per cycle while res_ready is high, set by the stage
//   update in the back end; front, queue and output register keep that rate.
//   reset: arst_n clears the stage to setup wait, the byte count, the zlp flag,
//   the device state to attached and both addresses to zero; no result pending.
//   stall: when res_ready is low the output register holds, the back end stops
//   draining the four-entry queue, and evt_ready drops once the queue and the
//   front registers are full; nothing is lost or repeated.
module usb_control_transfer_sequencer #(
	parameter int MAX_PACKET = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_ready,
	input  ucts_pkg::evt_item_t evt,
	output logic                res_valid,
	input  logic                res_ready,
	output ucts_pkg::res_item_t res
);

	logic               fq_valid;
	logic               fq_ready;
	ucts_pkg::cls_evt_t fq_data;
	logic               qb_valid;
	logic               qb_ready;
	ucts_pkg::cls_evt_t qb_data;

	// accept and classify
	ucts_front #(
		.MAX_PACKET(MAX_PACKET)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data)
	);

	// decoupling queue
	ucts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data (fq_data),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_data)
	);

	// stage sequencing and result
	ucts_back #(
		.MAX_PACKET(MAX_PACKET)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_data (qb_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// only a sent chunk carries a length
	a_len_only_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.command != ucts_pkg::CMD_SEND_CHUNK |-> res.chunk_length == '0)
		else $error("chunk length set on a non-chunk command");

	// a chunk is at most one packet and leaves the stage in data in
	a_chunk_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.command == ucts_pkg::CMD_SEND_CHUNK |->
		res.stage_now == ucts_pkg::STG_DATA_IN &&
		res.chunk_length <= 7'(MAX_PACKET))
		else $error("bad chunk command");

	// commands that end a transfer leave the stage in setup wait
	a_end_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.command == ucts_pkg::CMD_ARM_SETUP ||
		res.command == ucts_pkg::CMD_DELIVER || res.command == ucts_pkg::CMD_STALL) |->
		res.stage_now == ucts_pkg::STG_SETUP)
		else $error("transfer end without return to setup wait");

	// arming status goes with the status stage
	a_status_stage: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.command == ucts_pkg::CMD_ARM_STATUS |->
		res.stage_now == ucts_pkg::STG_STATUS_IN)
		else $error("status armed outside status stage");

endmodule
